// File: src/hrca_pkg.sv
`timescale 1ns / 1ps
// shared widths, slot entry type and relation codes for the conditional add unit
// no dependencies; imported by every module of the block

package hrca_pkg;

  // slot count must have the form 2**SLOT_BITS - 1 (the hash folds on that)
  localparam int TABLE_ENTRIES = 8191;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES + 1);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W = 63;
  localparam int AMT_W = 32;
  localparam int REL_W = 3;
  localparam int VAL_W = 64;

  localparam int IN_FIELDS_W  = 2 * KEY_W + 2 * AMT_W + 1 + REL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * VAL_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [REL_W-1:0] REL_LT = 3'd0;
  localparam logic [REL_W-1:0] REL_GT = 3'd1;
  localparam logic [REL_W-1:0] REL_EQ = 3'd2;
  localparam logic [REL_W-1:0] REL_LE = 3'd3;
  localparam logic [REL_W-1:0] REL_GE = 3'd4;
  localparam logic [REL_W-1:0] REL_NE = 3'd5;

  localparam logic [VAL_W-1:0] PEAK_RESET = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// File: src/hashed_register_conditional_add_unit.sv
`timescale 1ns / 1ps
// top level: slot memory, probe sequencer, conditional update and result register
// depends on hrca_pkg and hrca_hash

// Registers named by 63-bit keys live in an 8191-slot linear-probing table held in one
// single-port-read, single-port-write memory with registered read data. After reset the
// block runs a clearing pass over every slot with s_tready low. One instruction is handled
// at a time: a hash through S_HASH1 and S_HASH2, then a probe of the target key and of the
// compare key that walks one slot per cycle from a start state, a capacity check, a write
// for each new key, and the compare, add and result states. The input opens again in the
// same cycle as the result appears; a new compare key whose free slot the target has just
// taken is walked again. A result waiting in the output register does not stop the next
// transaction from being accepted.

module hashed_register_conditional_add_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_key, amount, is_decrement, compare_key, relation, compare_value, zero fill
  input  logic [hrca_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // target_value, running_peak, condition_met, table_full, zero fill
  output logic [hrca_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import hrca_pkg::*;

  localparam int OFS_AMT  = KEY_W;
  localparam int OFS_DEC  = OFS_AMT + AMT_W;
  localparam int OFS_CKEY = OFS_DEC + 1;
  localparam int OFS_REL  = OFS_CKEY + KEY_W;
  localparam int OFS_CVAL = OFS_REL + REL_W;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH1  = 4'd2;
  localparam logic [3:0] S_HASH2  = 4'd3;
  localparam logic [3:0] S_PSTART = 4'd4;
  localparam logic [3:0] S_PROBE  = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_INS_T  = 4'd7;
  localparam logic [3:0] S_INS_C  = 4'd8;
  localparam logic [3:0] S_COND   = 4'd9;
  localparam logic [3:0] S_UPDATE = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  localparam logic [1:0] PH_T  = 2'd0;
  localparam logic [1:0] PH_C  = 2'd1;
  localparam logic [1:0] PH_C2 = 2'd2;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_ENTRIES - 1);

  entry_t slot_mem [TABLE_ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [SLOT_BITS-1:0] wr_addr;
  logic                 wr_en;

  logic [3:0] state;
  logic [1:0] phase;
  logic [SLOT_BITS-1:0] clr_idx;
  logic [USED_W-1:0]    used;
  logic [VAL_W-1:0]     peak;

  logic [KEY_W-1:0] tkey;
  logic [KEY_W-1:0] ckey;
  logic [AMT_W-1:0] amt;
  logic             dec;
  logic [REL_W-1:0] rel;
  logic [AMT_W-1:0] cval;

  logic [SLOT_BITS-1:0] t_home;
  logic [SLOT_BITS-1:0] c_home;
  logic [SLOT_BITS-1:0] iss_idx;
  logic [SLOT_BITS-1:0] chk_idx;
  logic [SLOT_BITS-1:0] chk_n;
  logic [SLOT_BITS-1:0] t_slot;
  logic [SLOT_BITS-1:0] c_slot;
  logic                 t_hit;
  logic                 c_hit;
  logic [VAL_W-1:0]     t_val;
  logic [VAL_W-1:0]     c_val;
  logic                 cond;
  logic [VAL_W-1:0]     inc_eff;
  logic [VAL_W-1:0]     res_tv;
  logic                 res_full;

  logic                 t_nz;
  logic                 c_probe;
  logic [KEY_W-1:0]     pkey;
  logic [SLOT_BITS-1:0] home_sel;
  logic [SLOT_BITS-1:0] iss_next;
  logic                 rd_hit;
  logic                 rd_empty;
  logic                 probe_done;
  logic [USED_W:0]      need;
  logic                 no_room;
  logic signed [VAL_W-1:0] cv_s;
  logic signed [VAL_W-1:0] cval_s;
  logic [VAL_W-1:0]     amt_ext;
  logic [VAL_W-1:0]     inc;
  logic                 cond_comb;
  logic [VAL_W-1:0]     tv_sum;
  logic [VAL_W-1:0]     new_peak;
  logic                 out_free;
  logic                 accept;

  hrca_hash u_hash_t (.clk(clk), .key(tkey), .home(t_home));
  hrca_hash u_hash_c (.clk(clk), .key(ckey), .home(c_home));

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data <= slot_mem[rd_addr];
  end

  assign t_nz     = tkey != '0;
  assign c_probe  = (ckey != '0) && (ckey != tkey);
  assign pkey     = (phase == PH_T) ? tkey : ckey;
  assign home_sel = (phase == PH_T) ? t_home : c_home;
  assign iss_next = (iss_idx == LAST_SLOT) ? '0 : iss_idx + 1'b1;
  assign rd_hit   = rd_data.key == pkey;
  assign rd_empty = rd_data.key == '0;
  assign probe_done = rd_hit || rd_empty || (chk_n == LAST_SLOT);

  assign need    = (USED_W+1)'(t_nz && !t_hit) + (USED_W+1)'(c_probe && !c_hit);
  assign no_room = ({1'b0, used} + need) > (USED_W+1)'(TABLE_ENTRIES);

  // same key for both: the compare sees the value from before the update
  assign cv_s    = (ckey == tkey) ? t_val : c_val;
  assign cval_s  = {{(VAL_W-AMT_W){cval[AMT_W-1]}}, cval};
  assign amt_ext = {{(VAL_W-AMT_W){amt[AMT_W-1]}}, amt};
  assign inc     = dec ? ('0 - amt_ext) : amt_ext;
  assign tv_sum  = t_val + inc_eff;
  assign new_peak = ($signed(res_tv) > $signed(peak)) ? res_tv : peak;

  always_comb begin
    case (rel)
      REL_LT:  cond_comb = cval_s > cv_s;
      REL_GT:  cond_comb = cv_s > cval_s;
      REL_EQ:  cond_comb = cv_s == cval_s;
      REL_LE:  cond_comb = cv_s <= cval_s;
      REL_GE:  cond_comb = cv_s >= cval_s;
      REL_NE:  cond_comb = cv_s != cval_s;
      default: cond_comb = 1'b0;
    endcase
  end

  always_comb begin
    rd_addr = iss_idx;
    wr_en   = 1'b0;
    wr_addr = t_slot;
    wr_data = '{key: tkey, value: '0};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      S_PSTART: begin
        rd_addr = home_sel;
      end
      S_INS_T: begin
        wr_en = 1'b1;
      end
      S_INS_C: begin
        wr_en   = 1'b1;
        wr_addr = c_slot;
        wr_data = '{key: ckey, value: '0};
      end
      S_UPDATE: begin
        wr_en   = t_nz;
        wr_data = '{key: tkey, value: tv_sum};
      end
      default: begin
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      phase    <= PH_T;
      clr_idx  <= '0;
      used     <= '0;
      peak     <= PEAK_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            tkey     <= s_tdata[KEY_W-1:0];
            amt      <= s_tdata[OFS_AMT +: AMT_W];
            dec      <= s_tdata[OFS_DEC];
            ckey     <= s_tdata[OFS_CKEY +: KEY_W];
            rel      <= s_tdata[OFS_REL +: REL_W];
            cval     <= s_tdata[OFS_CVAL +: AMT_W];
            t_hit    <= 1'b0;
            c_hit    <= 1'b0;
            t_val    <= '0;
            c_val    <= '0;
            res_full <= 1'b0;
            state    <= S_HASH1;
          end
        end
        S_HASH1: begin
          state <= S_HASH2;
        end
        S_HASH2: begin
          if (t_nz) begin
            phase <= PH_T;
            state <= S_PSTART;
          end else if (c_probe) begin
            phase <= PH_C;
            state <= S_PSTART;
          end else begin
            state <= S_CHECK;
          end
        end
        S_PSTART: begin
          chk_idx <= home_sel;
          iss_idx <= (home_sel == LAST_SLOT) ? '0 : home_sel + 1'b1;
          chk_n   <= '0;
          state   <= S_PROBE;
        end
        S_PROBE: begin
          // reads run one slot ahead; the one in flight is dropped on a stop
          if (probe_done) begin
            case (phase)
              PH_T: begin
                t_hit  <= rd_hit;
                t_slot <= chk_idx;
                t_val  <= rd_hit ? rd_data.value : '0;
                if (c_probe) begin
                  phase <= PH_C;
                  state <= S_PSTART;
                end else begin
                  state <= S_CHECK;
                end
              end
              PH_C: begin
                c_hit  <= rd_hit;
                c_slot <= chk_idx;
                c_val  <= rd_hit ? rd_data.value : '0;
                state  <= S_CHECK;
              end
              default: begin
                c_slot <= chk_idx;
                state  <= S_INS_C;
              end
            endcase
          end else begin
            chk_idx <= iss_idx;
            iss_idx <= iss_next;
            chk_n   <= chk_n + 1'b1;
          end
        end
        S_CHECK: begin
          if (no_room) begin
            res_full <= 1'b1;
            state    <= S_OUT;
          end else if (t_nz && !t_hit) begin
            state <= S_INS_T;
          end else if (c_probe && !c_hit) begin
            state <= S_INS_C;
          end else begin
            state <= S_COND;
          end
        end
        S_INS_T: begin
          used <= used + 1'b1;
          // the compare key's free slot was just taken by the target: walk again
          if (c_probe && !c_hit && c_slot == t_slot) begin
            phase <= PH_C2;
            state <= S_PSTART;
          end else if (c_probe && !c_hit) begin
            state <= S_INS_C;
          end else begin
            state <= S_COND;
          end
        end
        S_INS_C: begin
          used  <= used + 1'b1;
          state <= S_COND;
        end
        S_COND: begin
          cond    <= cond_comb;
          inc_eff <= cond_comb ? inc : '0;
          state   <= S_UPDATE;
        end
        S_UPDATE: begin
          res_tv <= tv_sum;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (res_full) begin
              m_tdata <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, 1'b1, 1'b0, peak,
                          {VAL_W{1'b0}}};
            end else begin
              peak    <= new_peak;
              m_tdata <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, 1'b0, cond, new_peak,
                          res_tv};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/hrca_hash.sv
`timescale 1ns / 1ps
// home slot of a key: key mod TABLE_ENTRIES by folding SLOT_BITS-wide chunks
// two register stages; depends on hrca_pkg

module hrca_hash (
  input  logic                          clk,
  input  logic [hrca_pkg::KEY_W-1:0]    key,
  output logic [hrca_pkg::SLOT_BITS-1:0] home
);
  import hrca_pkg::*;

  localparam int CHUNKS = (KEY_W + SLOT_BITS - 1) / SLOT_BITS;
  localparam int PAD_W  = CHUNKS * SLOT_BITS;
  localparam int SUM_W  = SLOT_BITS + $clog2(CHUNKS);
  localparam int FOLD_W = SLOT_BITS + 1;

  logic [PAD_W-1:0]  key_pad;
  logic [SUM_W-1:0]  sum_comb;
  logic [SUM_W-1:0]  sum;
  logic [FOLD_W-1:0] fold;

  assign key_pad = {{(PAD_W - KEY_W){1'b0}}, key};

  // 2**SLOT_BITS is 1 modulo the slot count, so chunks simply add up
  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      sum_comb = sum_comb + SUM_W'(key_pad[i*SLOT_BITS +: SLOT_BITS]);
    end
  end

  assign fold = FOLD_W'(sum[SLOT_BITS-1:0]) + FOLD_W'(sum[SUM_W-1:SLOT_BITS]);

  always_ff @(posedge clk) begin
    sum <= sum_comb;
    if (fold >= FOLD_W'(TABLE_ENTRIES)) begin
      home <= SLOT_BITS'(fold - FOLD_W'(TABLE_ENTRIES));
    end else begin
      home <= fold[SLOT_BITS-1:0];
    end
  end

endmodule

// File: src/hrca_checker.sv
`timescale 1ns / 1ps
// port-level checks for the conditional add unit, bound to the top level
// depends on hrca_pkg and hashed_register_conditional_add_unit

module hrca_props (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [hrca_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [hrca_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import hrca_pkg::*;

  localparam int OFS_PEAK = VAL_W;
  localparam int OFS_COND = 2 * VAL_W;
  localparam int OFS_FULL = OFS_COND + 1;

  // the clearing pass keeps the input closed straight after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input open during clearing pass");

  // one instruction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OFS_FULL] |->
      !m_tdata[OFS_COND] && (m_tdata[VAL_W-1:0] == '0))
    else $error("table full result carries an update");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OFS_FULL] |->
      $signed(m_tdata[OFS_PEAK +: VAL_W]) >= $signed(m_tdata[VAL_W-1:0]))
    else $error("running peak below target value");

endmodule

bind hashed_register_conditional_add_unit hrca_props u_checker (.*);

// File: tb/hrca_checker.sv
`timescale 1ns / 1ps
// result checker for the conditional add unit: predicts every result from its own slot table
// and compares results against the outstanding expectations in order; depends on hrca_pkg

module hrca_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  // target_key, amount, is_decrement, compare_key, relation, compare_value, zero fill
  input  logic [hrca_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // target_value, running_peak, condition_met, table_full, zero fill
  input  logic [hrca_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                               errors,
  output int                               pending,
  output int                               full_count
);

  import hrca_pkg::*;

  localparam int AMT_LSB  = KEY_W;
  localparam int DEC_BIT  = AMT_LSB + AMT_W;
  localparam int CKEY_LSB = DEC_BIT + 1;
  localparam int REL_LSB  = CKEY_LSB + KEY_W;
  localparam int CVAL_LSB = REL_LSB + REL_W;

  typedef enum int {PROBE_NONE, PROBE_EMPTY, PROBE_HIT} probe_t;

  typedef struct {
    bit        [KEY_W-1:0] target_key;
    bit signed [AMT_W-1:0] amount;
    bit                    is_decrement;
    bit        [KEY_W-1:0] compare_key;
    bit        [REL_W-1:0] relation;
    bit signed [AMT_W-1:0] compare_value;
  } instr_t;

  typedef struct {
    bit signed [VAL_W-1:0] target_value;
    bit signed [VAL_W-1:0] running_peak;
    bit                    condition_met;
    bit                    table_full;
  } outcome_t;

  bit        [KEY_W-1:0] slot_key [TABLE_ENTRIES];
  bit        [VAL_W-1:0] slot_val [TABLE_ENTRIES];
  bit signed [VAL_W-1:0] peak;
  int                    occupied;
  outcome_t              awaited [$];

  // walk forward from the home slot until the key or a free slot turns up
  function automatic probe_t probe_slot(input bit [KEY_W-1:0] key, output int slot);
    int idx;
    idx  = int'(key % TABLE_ENTRIES);
    slot = idx;
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (slot_key[idx] == '0) begin
        slot = idx;
        return PROBE_EMPTY;
      end
      if (slot_key[idx] == key) begin
        slot = idx;
        return PROBE_HIT;
      end
      idx = (idx == TABLE_ENTRIES - 1) ? 0 : idx + 1;
    end
    return PROBE_NONE;
  endfunction

  function automatic int claim_slot(input bit [KEY_W-1:0] key);
    int slot;
    if (probe_slot(key, slot) == PROBE_EMPTY) begin
      slot_key[slot] = key;
      slot_val[slot] = '0;
      occupied++;
    end
    return slot;
  endfunction

  function automatic outcome_t apply_instr(input instr_t ins);
    outcome_t              res;
    int                    slot, tslot, cslot, need;
    bit signed [VAL_W-1:0] cur_t, cur_c, bound, step;
    bit                    cond;
    need  = 0;
    tslot = 0;
    cslot = 0;
    cur_t = '0;
    cur_c = '0;
    if (ins.target_key != '0 && probe_slot(ins.target_key, slot) != PROBE_HIT)
      need++;
    if (ins.compare_key != '0 && ins.compare_key != ins.target_key &&
        probe_slot(ins.compare_key, slot) != PROBE_HIT)
      need++;
    if (occupied + need > TABLE_ENTRIES) begin
      res.target_value  = '0;
      res.running_peak  = peak;
      res.condition_met = 1'b0;
      res.table_full    = 1'b1;
      return res;
    end
    // target goes in first; a shared key reads its value from before the update
    if (ins.target_key != '0) begin
      tslot = claim_slot(ins.target_key);
      cur_t = slot_val[tslot];
    end
    if (ins.compare_key != '0) begin
      cslot = claim_slot(ins.compare_key);
      cur_c = slot_val[cslot];
    end
    bound = ins.compare_value;
    case (ins.relation)
      REL_LT:  cond = cur_c < bound;
      REL_GT:  cond = cur_c > bound;
      REL_EQ:  cond = cur_c == bound;
      REL_LE:  cond = cur_c <= bound;
      REL_GE:  cond = cur_c >= bound;
      REL_NE:  cond = cur_c != bound;
      default: cond = 1'b0;
    endcase
    step = ins.amount;
    if (ins.is_decrement)
      step = -step;
    if (cond)
      cur_t = cur_t + step;
    if (ins.target_key != '0)
      slot_val[tslot] = cur_t;
    if (cur_t > peak)
      peak = cur_t;
    res.target_value  = cur_t;
    res.running_peak  = peak;
    res.condition_met = cond;
    res.table_full    = 1'b0;
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    instr_t   ins;
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      peak     = PEAK_RESET;
      occupied = 0;
      awaited.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          errors++;
          $error("result transaction with no instruction outstanding");
        end else begin
          want = awaited.pop_front();
          check_field("target_value", want.target_value, $signed(m_tdata[VAL_W-1:0]));
          check_field("running_peak", want.running_peak,
                      $signed(m_tdata[2*VAL_W-1:VAL_W]));
          check_field("condition_met", longint'(want.condition_met),
                      longint'(m_tdata[2*VAL_W]));
          check_field("table_full", longint'(want.table_full),
                      longint'(m_tdata[2*VAL_W+1]));
        end
      end
      if (s_tvalid && s_tready) begin
        ins.target_key    = s_tdata[KEY_W-1:0];
        ins.amount        = s_tdata[AMT_LSB +: AMT_W];
        ins.is_decrement  = s_tdata[DEC_BIT];
        ins.compare_key   = s_tdata[CKEY_LSB +: KEY_W];
        ins.relation      = s_tdata[REL_LSB +: REL_W];
        ins.compare_value = s_tdata[CVAL_LSB +: AMT_W];
        want = apply_instr(ins);
        if (want.table_full)
          full_count++;
        awaited.push_back(want);
      end
    end
    pending <= awaited.size();
  end

endmodule

// File: tb/hashed_register_conditional_add_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the conditional add unit: clock, reset, instruction stimulus and verdict
// depends on hrca_pkg, hrca_checker and the unit itself

module hashed_register_conditional_add_unit_tb;

  import hrca_pkg::*;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int STALL_LIMIT    = 100000;

  localparam logic [REL_W-1:0] REL_SPARE_LO = 3'd6;
  localparam logic [REL_W-1:0] REL_SPARE_HI = 3'd7;
  localparam logic [AMT_W-1:0] AMT_MIN      = 32'h8000_0000;
  localparam logic [AMT_W-1:0] AMT_MAX      = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_MAX      = '1;
  localparam logic [KEY_W-1:0] KEY_SPAN     = KEY_W'(TABLE_ENTRIES);

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors, pending, full_count;
  int send_idle = 0;
  int recv_idle = 0;
  int sent      = 0;
  bit holdoff_req  = 1'b0;
  bit holdoff_done = 1'b0;

  logic [KEY_W-1:0] key_pool [$];

  hashed_register_conditional_add_unit uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  hrca_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .errors, .pending, .full_count
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req && !holdoff_done) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic issue(input logic [KEY_W-1:0] tkey, input logic [AMT_W-1:0] amt,
                       input logic dec, input logic [KEY_W-1:0] ckey,
                       input logic [REL_W-1:0] rel, input logic [AMT_W-1:0] cval);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_FIELDS_W-1:0] = {cval, rel, ckey, dec, amt, tkey};
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_wide_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'({$urandom, $urandom});
    if (k == '0)
      k = 63'd1;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4)
      return '0;
    if (roll < 12)
      return rand_wide_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55)
      return int'($urandom_range(20)) - 10;
    if (roll < 65)
      return $urandom_range(1) ? AMT_MIN : AMT_MAX;
    return $urandom;
  endfunction

  function automatic logic [AMT_W-1:0] pick_bound();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)
      return int'($urandom_range(24)) - 12;
    if (roll < 60)
      return $urandom_range(1) ? AMT_MIN : AMT_MAX;
    return $urandom;
  endfunction

  task automatic random_instr();
    logic [KEY_W-1:0] tkey, ckey;
    tkey = pick_key();
    ckey = ($urandom_range(9) == 0) ? tkey : pick_key();
    issue(tkey, pick_amount(), 1'($urandom_range(1)), ckey, REL_W'($urandom_range(7)),
          pick_bound());
  endtask

  task automatic directed();
    logic [KEY_W-1:0] ka, kb, wrap;
    ka   = 63'd1;
    kb   = KEY_MAX;
    wrap = KEY_W'(TABLE_ENTRIES - 1);
    // first result is negative so the peak leaves its reset value
    issue(ka, 32'd5, 1'b1, ka, REL_EQ, 32'd0);
    issue(ka, 32'd3, 1'b0, ka, REL_EQ, 32'd0);
    issue(kb, AMT_MAX, 1'b0, ka, REL_GT, -32'sd6);
    issue(kb, AMT_MIN, 1'b1, kb, REL_GE, AMT_MAX);
    issue(kb, AMT_MIN, 1'b0, ka, REL_LT, -32'sd5);
    issue(kb, AMT_MIN, 1'b0, ka, REL_LE, -32'sd5);
    issue(ka, 32'd9, 1'b1, kb, REL_NE, 32'd0);
    issue(ka, AMT_MAX, 1'b0, kb, REL_SPARE_LO, 32'd0);
    issue(ka, AMT_MAX, 1'b0, kb, REL_SPARE_HI, 32'd0);
    // scratch register on one side or both
    issue('0, 32'd7, 1'b0, ka, REL_LT, 32'd0);
    issue('0, 32'd7, 1'b1, '0, REL_EQ, 32'd0);
    issue(ka, 32'd1, 1'b0, '0, REL_GE, AMT_MIN);
    // keys sharing the last home slot spill over into slot 0
    issue(wrap, 32'd11, 1'b0, wrap + KEY_SPAN, REL_EQ, 32'd0);
    issue(wrap + KEY_SPAN + KEY_SPAN, 32'd13, 1'b1, wrap + KEY_SPAN, REL_GE, 32'd0);
    issue(wrap + KEY_SPAN, AMT_MIN, 1'b1, wrap + KEY_SPAN + KEY_SPAN, REL_LT, 32'd0);
    issue(KEY_SPAN, 32'd2, 1'b0, wrap, REL_GT, 32'd10);
    issue(kb, 32'hffff_ffff, 1'b0, wrap, REL_GT, AMT_MIN);
    issue(kb, 32'd0, 1'b0, wrap, REL_LT, AMT_MAX);
  endtask

  task automatic build_pool();
    logic [KEY_W-1:0] base;
    repeat (24) key_pool.push_back(rand_wide_key());
    // short chains of keys with one home slot each
    repeat (3) begin
      base = (rand_wide_key() >> 4) | 63'd1;
      for (int j = 0; j < 4; j++)
        key_pool.push_back(base + KEY_W'(j * TABLE_ENTRIES));
    end
    for (int j = 0; j < 3; j++)
      key_pool.push_back(KEY_W'(TABLE_ENTRIES - 1 + j * TABLE_ENTRIES));
    key_pool.push_back(KEY_SPAN);
    key_pool.push_back(63'd1);
    key_pool.push_back(KEY_MAX);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    directed();
    build_pool();
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        send_idle = 8;
        recv_idle = 87;
      end else if (n == RANDOM_ITEMS / 3) begin
        send_idle = 87;
        recv_idle = 8;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle   = 0;
        recv_idle   = 0;
        holdoff_req = 1'b1;
      end else if (n == 5 * RANDOM_ITEMS / 6) begin
        drain();
      end
      random_instr();
    end
    drain();
    repeat (40) @(posedge clk);
    $display("summary: %0d instructions, %0d of them refused with the table full",
             sent, full_count);
    $display("summary: all relations, scratch and shared keys, probe chains, wraparound");
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
src/hrca_pkg.sv
src/hrca_hash.sv
src/hashed_register_conditional_add_unit.sv
src/hrca_checker.sv
tb/hrca_checker.sv
tb/hashed_register_conditional_add_unit_tb.sv
